[sv/clle_pkg.sv]
// clle_pkg: payload structs, pool size and command codes for the cursor linked list engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package clle_pkg;
  localparam int POOL = 128;
  localparam int AW   = $clog2(POOL);

  localparam logic [2:0] CMD_MAKE_EMPTY  = 3'd0;
  localparam logic [2:0] CMD_INSERT      = 3'd1;
  localparam logic [2:0] CMD_DELETE      = 3'd2;
  localparam logic [2:0] CMD_FIND        = 3'd3;
  localparam logic [2:0] CMD_FIND_PREV   = 3'd4;
  localparam logic [2:0] CMD_DELETE_LIST = 3'd5;
  localparam logic [2:0] CMD_READ_NODE   = 3'd6;
  localparam logic [2:0] CMD_NONE        = 3'd7;

  typedef struct packed {
    logic [2:0]         command;
    logic [6:0]         list_head;
    logic [6:0]         position;
    logic signed [31:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [6:0]         result_position;
    logic signed [31:0] node_element;
    logic [6:0]         node_next;
    logic               found;
    logic               status;
  } out_item_t;
endpackage
`default_nettype wire

[sv/cursor_linked_list_engine.sv]
// cursor_linked_list_engine: top level, input queue in front of the node sequencer
// depends on clle_pkg, clle_front, clle_back
`timescale 1ns / 1ps
`default_nettype none
// Commands are taken into a two-deep queue and run one at a time by a
// sequencer over one link memory and one element memory, each with a single
// registered read port. Find and find_previous compare one node at a time
// down the list, delete also unlinks the node that it finds, delete_list
// frees the nodes of the list one by one, and make_empty does the same and
// then allocates a new header. The sequencer moves on to the next command
// while a result waits and only holds at the end of that command until the
// result is taken. After reset a pass over the pool builds the free list
// before the first command is started; commands may still be queued
// meanwhile.
module cursor_linked_list_engine (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  clle_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output clle_pkg::out_item_t out_item
);
  import clle_pkg::*;

  logic     q_valid, q_ready;
  in_item_t q_item;

  clle_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .q_valid, .q_ready, .q_item
  );

  clle_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_item
  );
endmodule
`default_nettype wire

[sv/clle_front.sv]
// clle_front: input skid queue, holds up to two accepted commands
// depends on clle_pkg
`timescale 1ns / 1ps
`default_nettype none
module clle_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  clle_pkg::in_item_t  in_item,
  output logic                q_valid,
  input  wire                 q_ready,
  output clle_pkg::in_item_t  q_item
);
  import clle_pkg::*;

  in_item_t   slot [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_full_no_push: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("push into full queue");
  a_empty_no_pop: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !pop) else $error("pop from empty queue");
`endif
endmodule
`default_nettype wire

[sv/clle_back.sv]
// clle_back: sequencer that walks the node pool and runs each command
// depends on clle_pkg
`timescale 1ns / 1ps
`default_nettype none
module clle_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 q_valid,
  output logic                q_ready,
  input  clle_pkg::in_item_t  q_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output clle_pkg::out_item_t out_item
);
  import clle_pkg::*;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // step codes inside a command
  localparam logic [3:0] P_CLR_HEAD = 4'd0;
  localparam logic [3:0] P_CLR_WALK = 4'd1;
  localparam logic [3:0] P_GIVE_A   = 4'd2;
  localparam logic [3:0] P_GIVE_B   = 4'd3;
  localparam logic [3:0] P_TAKE_A   = 4'd4;
  localparam logic [3:0] P_TAKE_B   = 4'd5;
  localparam logic [3:0] P_ME_FIN   = 4'd6;
  localparam logic [3:0] P_INS_POS  = 4'd7;
  localparam logic [3:0] P_INS_FIN  = 4'd8;
  localparam logic [3:0] P_WALK     = 4'd9;
  localparam logic [3:0] P_WALK_EL  = 4'd10;
  localparam logic [3:0] P_READ     = 4'd11;

  logic [AW-1:0] links [POOL];
  logic [31:0]   elems [POOL];

  logic [2:0]    state;
  logic [3:0]    phase;
  logic [AW-1:0] init_cnt;
  logic [AW-1:0] rd_addr, link_q;
  logic [31:0]   elem_q;
  in_item_t      cmd;
  logic [AW-1:0] head, pos, cur, nxt, tnode;
  logic [AW:0]   steps;
  logic          hit, oos;
  logic          match;
  logic          lw_en, ew_en;
  logic [AW-1:0] lw_addr, lw_data, ew_addr;
  logic [31:0]   ew_data;
  logic          res_valid;
  logic          done_fire;
  out_item_t     res, res_next;

  assign q_ready   = (state == S_IDLE);
  assign out_valid = res_valid;
  assign out_item  = res;
  assign match     = (elem_q == cmd.element_value);
  assign done_fire = (state == S_DONE) && (!res_valid || out_ready);
  assign ew_en     = (state == S_EVAL) && (phase == P_TAKE_B) && (cmd.command == CMD_INSERT);
  assign ew_addr   = tnode;
  assign ew_data   = cmd.element_value;

  always_comb begin
    lw_en   = 1'b0;
    lw_addr = '0;
    lw_data = '0;
    if (state == S_INIT) begin
      lw_en   = 1'b1;
      lw_addr = init_cnt;
      lw_data = init_cnt + 1'b1;
    end else if (state == S_EVAL) begin
      unique case (phase)
        P_CLR_HEAD: begin
          lw_en   = 1'b1;
          lw_addr = head;
        end
        P_GIVE_A: begin
          lw_en   = 1'b1;
          lw_addr = tnode;
          lw_data = link_q;
        end
        P_GIVE_B: begin
          lw_en   = 1'b1;
          lw_data = tnode;
        end
        P_TAKE_B: begin
          lw_en   = 1'b1;
          lw_data = link_q;
        end
        P_ME_FIN: begin
          lw_en   = 1'b1;
          lw_addr = tnode;
        end
        P_INS_POS: begin
          lw_en   = 1'b1;
          lw_addr = tnode;
          lw_data = link_q;
        end
        P_INS_FIN: begin
          lw_en   = 1'b1;
          lw_addr = pos;
          lw_data = tnode;
        end
        P_WALK_EL: begin
          lw_en   = match && (cmd.command == CMD_DELETE);
          lw_addr = cur;
          lw_data = link_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (lw_en) links[lw_addr] <= lw_data;
    if (ew_en) elems[ew_addr] <= ew_data;
    link_q <= links[rd_addr];
    elem_q <= elems[rd_addr];
  end

  always_comb begin
    res_next = '0;
    unique case (cmd.command) inside
      CMD_MAKE_EMPTY, CMD_INSERT: begin
        res_next.status          = oos;
        res_next.result_position = oos ? '0 : tnode;
      end
      CMD_FIND: begin
        res_next.found           = hit;
        res_next.result_position = hit ? nxt : '0;
      end
      CMD_DELETE, CMD_FIND_PREV: begin
        res_next.found           = hit;
        res_next.result_position = cur;
      end
      CMD_READ_NODE: begin
        res_next.result_position = pos;
        res_next.node_element    = elem_q;
        res_next.node_next       = link_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      phase     <= P_READ;
      init_cnt  <= '0;
      steps     <= '0;
      cmd       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (done_fire) res_valid <= 1'b1;
      else if (out_ready) res_valid <= 1'b0;
      unique case (state)
        S_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == AW'(POOL - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd   <= q_item;
            head  <= q_item.list_head;
            pos   <= q_item.position;
            cur   <= q_item.list_head;
            nxt   <= '0;
            tnode <= '0;
            hit   <= 1'b0;
            oos   <= 1'b0;
            steps <= '0;
            unique case (q_item.command) inside
              CMD_MAKE_EMPTY: begin
                state <= S_RD;
                if (q_item.list_head != '0) begin
                  phase   <= P_CLR_HEAD;
                  rd_addr <= q_item.list_head;
                end else begin
                  phase   <= P_TAKE_A;
                  rd_addr <= '0;
                end
              end
              CMD_INSERT: begin
                state   <= S_RD;
                phase   <= P_TAKE_A;
                rd_addr <= '0;
              end
              CMD_DELETE, CMD_FIND, CMD_FIND_PREV: begin
                state   <= S_RD;
                phase   <= P_WALK;
                rd_addr <= q_item.list_head;
              end
              CMD_DELETE_LIST: begin
                state   <= S_RD;
                phase   <= P_CLR_HEAD;
                rd_addr <= q_item.list_head;
              end
              CMD_READ_NODE: begin
                state   <= S_RD;
                phase   <= P_READ;
                rd_addr <= q_item.position;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_RD: state <= S_EVAL;
        S_EVAL: begin
          unique case (phase)
            P_CLR_HEAD: begin
              // link_q = first node of the list, header link cleared now
              cur <= link_q;
              if (link_q != '0) begin
                phase   <= P_CLR_WALK;
                rd_addr <= link_q;
                state   <= S_RD;
              end else if (cmd.command == CMD_MAKE_EMPTY) begin
                phase   <= P_TAKE_A;
                rd_addr <= '0;
                state   <= S_RD;
              end else begin
                state <= S_DONE;
              end
            end
            P_CLR_WALK: begin
              // link_q = next of cur, then read the free head
              nxt     <= link_q;
              tnode   <= cur;
              phase   <= P_GIVE_A;
              rd_addr <= '0;
              state   <= S_RD;
            end
            P_GIVE_A: begin
              phase <= P_GIVE_B;
              state <= S_EVAL;
            end
            P_GIVE_B: begin
              if (cmd.command == CMD_DELETE) begin
                state <= S_DONE;
              end else begin
                steps <= steps + 1'b1;
                cur   <= nxt;
                if (nxt != '0 && (steps + 1'b1) != (AW+1)'(POOL)) begin
                  phase   <= P_CLR_WALK;
                  rd_addr <= nxt;
                  state   <= S_RD;
                end else if (cmd.command == CMD_MAKE_EMPTY) begin
                  phase   <= P_TAKE_A;
                  rd_addr <= '0;
                  state   <= S_RD;
                end else begin
                  state <= S_DONE;
                end
              end
            end
            P_TAKE_A: begin
              // link_q = node to take
              tnode <= link_q;
              if (link_q == '0) begin
                oos   <= 1'b1;
                state <= S_DONE;
              end else begin
                phase   <= P_TAKE_B;
                rd_addr <= link_q;
                state   <= S_RD;
              end
            end
            P_TAKE_B: begin
              if (cmd.command == CMD_INSERT) begin
                phase   <= P_INS_POS;
                rd_addr <= pos;
                state   <= S_RD;
              end else begin
                phase <= P_ME_FIN;
                state <= S_EVAL;
              end
            end
            P_ME_FIN: state <= S_DONE;
            P_INS_POS: begin
              phase <= P_INS_FIN;
              state <= S_EVAL;
            end
            P_INS_FIN: state <= S_DONE;
            P_WALK: begin
              // link_q = first node after the header
              nxt <= link_q;
              if (link_q == '0) begin
                state <= S_DONE;
              end else begin
                phase   <= P_WALK_EL;
                rd_addr <= link_q;
                state   <= S_RD;
              end
            end
            P_WALK_EL: begin
              // elem_q = element of nxt, link_q = next of nxt
              if (match) begin
                hit <= 1'b1;
                if (cmd.command == CMD_DELETE) begin
                  tnode   <= nxt;
                  phase   <= P_GIVE_A;
                  rd_addr <= '0;
                  state   <= S_RD;
                end else begin
                  state <= S_DONE;
                end
              end else begin
                steps <= steps + 1'b1;
                cur   <= nxt;
                if ((steps + 1'b1) == (AW+1)'(POOL) || link_q == '0) begin
                  state <= S_DONE;
                end else begin
                  nxt     <= link_q;
                  rd_addr <= link_q;
                  state   <= S_RD;
                end
              end
            end
            P_READ: state <= S_DONE;
            default: state <= S_DONE;
          endcase
        end
        S_DONE: begin
          if (done_fire) begin
            res   <= res_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_ready |=> res_valid && $stable(res)) else $error("result dropped");
  a_init_no_accept: assert property (@(posedge clk) disable iff (rst)
    state == S_INIT |-> !q_ready) else $error("accept during init");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    steps <= (AW+1)'(POOL)) else $error("walk overran pool");
`endif
endmodule
`default_nettype wire
